/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define OTBO_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("otbo check failed");

// condition that must never be true out of reset
`define OTBO_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("otbo forbidden condition seen");

`endif

/* hdl/otbo_pkg.sv */
// ----------------------------------------------------------------------------
// otbo_pkg
// types, codes and sizes shared by the object table overlap search block
// ----------------------------------------------------------------------------
package otbo_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_UPDATE  = 3'd1;
  localparam logic [2:0] ACT_DESTROY = 3'd2;
  localparam logic [2:0] ACT_SWEEP   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_FIND    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        entry_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]        size_w;
    logic [9:0]        size_h;
    logic [7:0]        tag;
    logic [7:0]        flags;
    logic              exclude_valid;
    logic [7:0]        exclude_index;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        result_index;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic [9:0]        hit_w;
    logic [9:0]        hit_h;
    logic [7:0]        hit_tag;
    logic [7:0]        hit_flags;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]        w;
    logic [9:0]        h;
    logic [7:0]        tag;
    logic [7:0]        flags;
  } box_t;

  typedef enum logic [2:0] {
    RK_OK,
    RK_CREATED,
    RK_FULL,
    RK_NONE,
    RK_HIT
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  scan;
    logic  upd;
    logic  dst;
    logic  swp;
    logic  clr;
    logic  crt;
    logic  res_set;
    kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       cnt_end;
    logic       cur_free;
    logic       issue_ok;
    logic       chk_vld;
    logic       hit;
  } sts_t;

endpackage

/* hdl/otbo_dp.sv */
// ----------------------------------------------------------------------------
// otbo_dp
// slot marks, box memory, scan counter, overlap test and result register
// ----------------------------------------------------------------------------
module otbo_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  otbo_pkg::in_t    in_data_i,
  input  otbo_pkg::cmd_t   cmd_i,
  output otbo_pkg::sts_t   sts_o,
  output otbo_pkg::out_t   res_o
);

  localparam int IW = otbo_pkg::IDX_W;
  localparam int CW = otbo_pkg::CNT_W;
  localparam int XW = CW + 8;

  otbo_pkg::in_t  item_q;
  otbo_pkg::box_t mem [otbo_pkg::ENTRIES];
  otbo_pkg::box_t rd_q;
  otbo_pkg::out_t res_q;
  otbo_pkg::out_t res_d;

  logic [otbo_pkg::ENTRIES-1:0] used_q;
  logic [otbo_pkg::ENTRIES-1:0] dying_q;
  logic [CW-1:0] hw_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] chk_idx_q;
  logic          chk_vld_q;

  otbo_pkg::box_t qbox;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          upd_ok;
  logic          rd_en;
  logic          tag_ok;
  logic          flag_ok;
  logic          excl;
  logic          ovl;
  logic signed [17:0] qx, qy, qx2, qy2, ex, ey, ex2, ey2;

  assign qbox.x     = item_q.pos_x;
  assign qbox.y     = item_q.pos_y;
  assign qbox.w     = item_q.size_w;
  assign qbox.h     = item_q.size_h;
  assign qbox.tag   = item_q.tag;
  assign qbox.flags = item_q.flags;

  assign upd_ok  = XW'(item_q.entry_index) < XW'(otbo_pkg::ENTRIES);
  assign wr_en   = cmd_i.crt || (cmd_i.upd && upd_ok);
  assign wr_addr = cmd_i.crt ? cnt_q[IW-1:0] : IW'(item_q.entry_index);
  assign rd_en   = cmd_i.scan && sts_o.issue_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= qbox;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[cnt_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (rd_en) begin
      chk_idx_q <= cnt_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      dying_q   <= '0;
      hw_q      <= '0;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q     <= '0;
        chk_vld_q <= 1'b0;
      end else begin
        if (cmd_i.cnt_inc || rd_en) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (cmd_i.scan) begin
          chk_vld_q <= rd_en;
        end
      end
      if (cmd_i.crt) begin
        used_q[cnt_q[IW-1:0]]  <= 1'b1;
        dying_q[cnt_q[IW-1:0]] <= 1'b0;
        if (hw_q < cnt_q + CW'(1)) begin
          hw_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.dst && upd_ok) begin
        dying_q[IW'(item_q.entry_index)] <= 1'b1;
      end
      if (cmd_i.swp) begin
        for (int i = 0; i < otbo_pkg::ENTRIES; i++) begin
          if (CW'(i) < hw_q && dying_q[i]) begin
            used_q[i] <= 1'b0;
          end
        end
      end
      if (cmd_i.clr) begin
        used_q[otbo_pkg::ENTRIES-1:1]  <= '0;
        dying_q[otbo_pkg::ENTRIES-1:1] <= '0;
        hw_q <= CW'(1);
      end
    end
  end

  // strict overlap on sign extended sums
  always_comb begin
    qx  = 18'(item_q.pos_x);
    qy  = 18'(item_q.pos_y);
    ex  = 18'(rd_q.x);
    ey  = 18'(rd_q.y);
    qx2 = qx + $signed({8'b0, item_q.size_w});
    qy2 = qy + $signed({8'b0, item_q.size_h});
    ex2 = ex + $signed({8'b0, rd_q.w});
    ey2 = ey + $signed({8'b0, rd_q.h});
    ovl = (qx < ex2) && (ex < qx2) && (qy < ey2) && (ey < qy2);
  end

  assign tag_ok  = (item_q.tag == 8'd0) || (rd_q.tag == item_q.tag);
  assign flag_ok = (rd_q.flags & item_q.flags) == item_q.flags;
  assign excl    = item_q.exclude_valid && (XW'(chk_idx_q) == XW'(item_q.exclude_index));

  assign sts_o.action   = item_q.action;
  assign sts_o.cnt_end  = cnt_q == CW'(otbo_pkg::ENTRIES);
  assign sts_o.cur_free = !used_q[cnt_q[IW-1:0]];
  assign sts_o.issue_ok = cnt_q < hw_q;
  assign sts_o.chk_vld  = chk_vld_q;
  assign sts_o.hit      = chk_vld_q && used_q[chk_idx_q] && !dying_q[chk_idx_q]
                          && tag_ok && flag_ok && !excl && ovl;

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      otbo_pkg::RK_CREATED: begin
        res_d.status       = otbo_pkg::ST_OK;
        res_d.result_index = 8'(cnt_q);
      end
      otbo_pkg::RK_FULL: begin
        res_d.status = otbo_pkg::ST_FULL;
      end
      otbo_pkg::RK_NONE: begin
        res_d.status = otbo_pkg::ST_NONE;
      end
      otbo_pkg::RK_HIT: begin
        res_d.status       = otbo_pkg::ST_OK;
        res_d.result_index = 8'(chk_idx_q);
        res_d.hit_x        = rd_q.x;
        res_d.hit_y        = rd_q.y;
        res_d.hit_w        = rd_q.w;
        res_d.hit_h        = rd_q.h;
        res_d.hit_tag      = rd_q.tag;
        res_d.hit_flags    = rd_q.flags;
      end
      default: begin
        res_d.status = otbo_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* hdl/otbo_ctrl.sv */
// ----------------------------------------------------------------------------
// otbo_ctrl
// sequencer for table actions and the output beat handshake
// ----------------------------------------------------------------------------
module otbo_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  otbo_pkg::sts_t sts_i,
  output otbo_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CSCAN = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]      state_q, state_d;
  otbo_pkg::kind_e kind_q, kind_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.res_kind = kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        kind_d = otbo_pkg::RK_OK;
        state_d = S_OUT;
        case (sts_i.action)
          otbo_pkg::ACT_CREATE: begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_CSCAN;
          end
          otbo_pkg::ACT_FIND: begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_FSCAN;
          end
          otbo_pkg::ACT_UPDATE:  cmd_o.upd = 1'b1;
          otbo_pkg::ACT_DESTROY: cmd_o.dst = 1'b1;
          otbo_pkg::ACT_SWEEP:   cmd_o.swp = 1'b1;
          otbo_pkg::ACT_CLEAR:   cmd_o.clr = 1'b1;
          default: ;
        endcase
      end
      S_CSCAN: begin
        if (sts_i.cnt_end) begin
          kind_d  = otbo_pkg::RK_FULL;
          state_d = S_OUT;
        end else if (sts_i.cur_free) begin
          cmd_o.crt = 1'b1;
          kind_d  = otbo_pkg::RK_CREATED;
          state_d = S_OUT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_FSCAN: begin
        if (sts_i.hit) begin
          kind_d  = otbo_pkg::RK_HIT;
          state_d = S_OUT;
        end else if (!sts_i.chk_vld && !sts_i.issue_ok) begin
          kind_d  = otbo_pkg::RK_NONE;
          state_d = S_OUT;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.res_set = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= otbo_pkg::RK_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/object_table_box_overlap_search_top.sv */
// ----------------------------------------------------------------------------
// object_table_box_overlap_search_top
// table of boxes with create, update, destroy, sweep, clear and overlap find
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one action beat;
//   output channel out_valid_o / out_stall_i / out_data_o returns one beat
//   for every input beat, in order.
//   update, destroy, sweep, clear and unknown actions go straight to the result.
//   create: scans from slot 0 for the first free slot, over all ENTRIES slots
//   at most, and reports full if none is free; the scan reads one slot mark per cycle.
//   find: scans from slot 0 up to the high-water mark and stops at the first hit;
//   the single read port of the box memory sets one slot per cycle.
//   one action is worked at a time; the next beat is taken once the result
//   sits in the output register, even while that beat is stalled.
//   reset clears all slot marks and the high-water mark; box contents are
//   not cleared. a stalled output beat holds, and a finished result waits
//   for the output register before the block takes new input.
// ----------------------------------------------------------------------------
module object_table_box_overlap_search_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  otbo_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output otbo_pkg::out_t out_data_o
);

  otbo_pkg::cmd_t cmd;
  otbo_pkg::sts_t sts;

  otbo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  otbo_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (out_data_o)
  );

endmodule

/* hdl/otbo_checker.sv */
// ----------------------------------------------------------------------------
// otbo_checker
// port level checks on the object table overlap search block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otbo_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input otbo_pkg::out_t out_data_o
);

  logic fail_beat;
  logic fail_clean;

  assign fail_beat  = out_valid_o && out_data_o.status != otbo_pkg::ST_OK;
  assign fail_clean = out_data_o.result_index == 8'd0 && out_data_o.hit_tag == 8'd0;

  `OTBO_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `OTBO_ASSERT(a_busy_after_beat, in_valid_i && !in_stall_o |=> in_stall_o)
  `OTBO_ASSERT(a_fail_zero, fail_beat |-> fail_clean)
  `OTBO_NEVER(a_status_code, out_valid_o && out_data_o.status > otbo_pkg::ST_NONE)

endmodule

bind object_table_box_overlap_search_top otbo_checker u_otbo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
